[rtl/rv32_pkg.sv]
`default_nettype none
package rv32_pkg;
	localparam logic [6:0] OP_R      = 7'b0110011;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_LUI    = 7'b0110111;
	localparam logic [6:0] OP_AUIPC  = 7'b0010111;
	localparam logic [6:0] OP_JAL    = 7'b1101111;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_IMM    = 7'b0010011;
	localparam logic [6:0] OP_JALR   = 7'b1100111;
	localparam logic [6:0] F7_ALT    = 7'b0100000;
	localparam logic [31:0] HALT_WORD = 32'h00000063;
	localparam logic [31:0] MEM_BASE_RESET = 32'h00010000;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_HALT    = 2'd1,
		ST_ILLEGAL = 2'd2,
		ST_WINDOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic        wr;
		logic [4:0]  rd;
		logic [31:0] val;
	} rf_wr_t;
endpackage
`default_nettype wire

[rtl/rv32i_subset_execute.sv]
`default_nettype none
// Pipeline: a request accepted into the first stage (register file read) moves to the
// execute stage (data memory read), and its result is then registered on the outputs,
// where out_valid rises; a stall on out_ready can hold either move.
// Throughput: one instruction per cycle while out_ready holds and no memory sweep runs,
// with forwarding of register and store values. Reset: arst_n clears pc, mem_base (to
// 0x00010000), the pipeline and register valid bits; the data memory is then swept to zero while in_ready stays low.
module rv32i_subset_execute
	import rv32_pkg::*;
#(
	parameter int MEM_WORDS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] instr,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      next_pc,
	output logic [1:0]       status,
	output logic             reg_write,
	output logic [4:0]       dest_reg,
	output logic [31:0]      dest_value,
	output logic             mem_write,
	output logic [4:0]       store_index,
	output logic [31:0]      store_value
);
	localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam logic [31:0] WIN_BYTES = 32'(4 * MEM_WORDS);

	logic [31:0] mem_base_q, pc_q;
	logic        v_s1, v_s2, ov_q;
	logic [31:0] ins_s1, ins_s2, a_s2, b_s2;
	logic        acc, adv1, adv2, clr_busy;
	logic [31:0] ra, rb, rf1, rf2, md, mraw;
	logic [31:0] fa, fb, a1_addr, a1_off;
	logic [4:0]  rs1, rs2, n_rs1, n_rs2;
	logic [AW-1:0] ridx;

	// Decode of the execute-stage instruction.
	logic [6:0] op, f7;
	logic [2:0] f3;
	logic [4:0] rd;
	logic [31:0] imm_i, imm_s, imm_b, imm_j, addr, off, npc, val;
	logic        wr, sw, take;
	status_t     st;
	logic [AW-1:0] widx;
	rf_wr_t      wp;
	logic        fw1_q, fw2_q, fwm_q;
	rf_wr_t      wp_last_q;
	logic [31:0] sv_last_q;

	assign pready = 1'b1;
	assign prdata = mem_base_q;
	assign adv2 = v_s2 && (!ov_q || out_ready);
	assign adv1 = v_s1 && (!v_s2 || adv2);
	assign in_ready = !clr_busy && (!v_s1 || adv1);
	assign acc = in_valid && in_ready;
	assign out_valid = ov_q;

	assign n_rs1 = instr[19:15];
	assign n_rs2 = instr[24:20];
	assign rs1 = ins_s1[19:15];
	assign rs2 = ins_s1[24:20];

	// Operands of the first stage: the instruction in execute has priority over the
	// write that landed when this request was accepted.
	always_comb begin
		fa = fw1_q ? wp_last_q.val : rf1;
		fb = fw2_q ? wp_last_q.val : rf2;
		if (v_s2 && wr && rd == rs1) begin
			fa = val;
		end
		if (v_s2 && wr && rd == rs2) begin
			fb = val;
		end
		a1_addr = fa + ((ins_s1[6:0] == OP_STORE) ?
			{{20{ins_s1[31]}}, ins_s1[31:25], ins_s1[11:7]} :
			{{20{ins_s1[31]}}, ins_s1[31:20]});
		a1_off = a1_addr - mem_base_q;
		ridx = a1_off[AW+1:2];
	end

	always_comb begin
		op = ins_s2[6:0];
		rd = ins_s2[11:7];
		f3 = ins_s2[14:12];
		f7 = ins_s2[31:25];
		imm_i = {{20{ins_s2[31]}}, ins_s2[31:20]};
		imm_s = {{20{ins_s2[31]}}, ins_s2[31:25], ins_s2[11:7]};
		imm_b = {{19{ins_s2[31]}}, ins_s2[31], ins_s2[7], ins_s2[30:25], ins_s2[11:8], 1'b0};
		imm_j = {{11{ins_s2[31]}}, ins_s2[31], ins_s2[19:12], ins_s2[20], ins_s2[30:21], 1'b0};
		ra = a_s2;
		rb = b_s2;
		addr = ra + ((op == OP_STORE) ? imm_s : imm_i);
		off = addr - mem_base_q;
		widx = off[AW+1:2];
		npc = pc_q + 32'd4;
		st = ST_OK;
		wr = 1'b0;
		sw = 1'b0;
		val = '0;
		take = 1'b0;
		if (ins_s2 == HALT_WORD) begin
			st = ST_HALT;
		end else begin
			case (op)
				OP_R: begin
					wr = 1'b1;
					if (f7 == 7'd0) begin
						case (f3)
							3'd0: val = ra + rb;
							3'd1: val = ra << rb[4:0];
							3'd2: val = {31'd0, $signed(ra) < $signed(rb)};
							3'd3: val = {31'd0, ra < rb};
							3'd4: val = ra ^ rb;
							3'd5: val = ra >> rb[4:0];
							3'd6: val = ra | rb;
							default: val = ra & rb;
						endcase
					end else if (f7 == F7_ALT && f3 == 3'd0) begin
						val = ra - rb;
					end else if (f7 == F7_ALT && f3 == 3'd5) begin
						val = $unsigned($signed(ra) >>> rb[4:0]);
					end else begin
						wr = 1'b0;
						st = ST_ILLEGAL;
					end
				end
				OP_IMM: begin
					if (f3 == 3'd0) begin
						wr = 1'b1;
						val = ra + imm_i;
					end else if (f3 == 3'd3) begin
						wr = 1'b1;
						val = {31'd0, ra < imm_i};
					end else begin
						st = ST_ILLEGAL;
					end
				end
				OP_LOAD, OP_STORE: begin
					if (f3 != 3'd2) begin
						st = ST_ILLEGAL;
					end else if (off[1:0] != 2'd0 || off >= WIN_BYTES) begin
						st = ST_WINDOW;
					end else if (op == OP_LOAD) begin
						wr = 1'b1;
						val = md;
					end else begin
						sw = 1'b1;
					end
				end
				OP_BRANCH: begin
					case (f3)
						3'd0: take = ra == rb;
						3'd1: take = ra != rb;
						3'd4: take = $signed(ra) < $signed(rb);
						3'd5: take = !($signed(ra) < $signed(rb));
						3'd6: take = ra < rb;
						3'd7: take = ra >= rb;
						default: st = ST_ILLEGAL;
					endcase
					if (take) begin
						npc = pc_q + imm_b;
					end
				end
				OP_LUI: begin
					wr = 1'b1;
					val = {ins_s2[31:12], 12'd0};
				end
				OP_AUIPC: begin
					wr = 1'b1;
					val = pc_q + {ins_s2[31:12], 12'd0};
				end
				OP_JAL: begin
					wr = 1'b1;
					val = pc_q + 32'd4;
					npc = pc_q + imm_j;
				end
				OP_JALR: begin
					if (f3 != 3'd0) begin
						st = ST_ILLEGAL;
					end else begin
						wr = 1'b1;
						val = pc_q + 32'd4;
						npc = (ra + imm_i) & ~32'd1;
					end
				end
				default: st = ST_ILLEGAL;
			endcase
		end
		if (st != ST_OK) begin
			npc = pc_q;
			wr = 1'b0;
			sw = 1'b0;
		end
		if (rd == 5'd0) begin
			wr = 1'b0;
		end
		wp.wr = wr && adv2;
		wp.rd = wr ? rd : 5'd0;
		wp.val = wr ? val : 32'd0;
	end

	// A store leaving execute in the cycle a load reads the same word bypasses the memory.
	assign md = fwm_q ? sv_last_q : mraw;

	rv32_regfile u_rf (
		.clk(clk), .arst_n(arst_n), .rd_en(acc), .ra1(n_rs1), .ra2(n_rs2),
		.wp(wp), .rd1(rf1), .rd2(rf2)
	);

	rv32_dmem #(.MEM_WORDS(MEM_WORDS), .AW(AW)) u_dmem (
		.clk(clk), .arst_n(arst_n), .rd_en(adv1), .ra(ridx),
		.we(sw && adv2), .wa(widx), .wd(rb), .rd(mraw), .busy(clr_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_base_q <= MEM_BASE_RESET;
			pc_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ov_q <= 1'b0;
			fw1_q <= 1'b0;
			fw2_q <= 1'b0;
			fwm_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && !paddr) begin
				mem_base_q <= pwdata;
			end
			if (adv2) begin
				pc_q <= npc;
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
				fwm_q <= sw && adv2 && widx == ridx;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (acc) begin
				v_s1 <= 1'b1;
				fw1_q <= wp.wr && wp.rd == n_rs1;
				fw2_q <= wp.wr && wp.rd == n_rs2;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ins_s1 <= instr;
		end
		if (adv1) begin
			ins_s2 <= ins_s1;
			a_s2 <= fa;
			b_s2 <= fb;
		end
		if (adv2) begin
			wp_last_q <= wp;
			sv_last_q <= rb;
			next_pc <= npc;
			status <= st;
			reg_write <= wr;
			dest_reg <= wp.rd;
			dest_value <= wp.val;
			mem_write <= sw;
			store_index <= sw ? 5'(widx) : 5'd0;
			store_value <= sw ? rb : 32'd0;
		end
	end
endmodule
`default_nettype wire

[rtl/rv32_regfile.sv]
`default_nettype none
module rv32_regfile
	import rv32_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rd_en,
	input  wire logic [4:0]  ra1,
	input  wire logic [4:0]  ra2,
	input  wire rf_wr_t      wp,
	output logic [31:0]      rd1,
	output logic [31:0]      rd2
);
	logic [31:0] mem [32];
	logic [31:0] valid_q;
	logic [31:0] q1_q, q2_q;
	logic        v1_q, v2_q;

	always_ff @(posedge clk) begin
		if (wp.wr) begin
			mem[wp.rd] <= wp.val;
		end
		if (rd_en) begin
			q1_q <= mem[ra1];
			q2_q <= mem[ra2];
		end
	end

	// Entries never written read as zero; x0 is never written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (wp.wr) begin
				valid_q[wp.rd] <= 1'b1;
			end
			if (rd_en) begin
				v1_q <= valid_q[ra1];
				v2_q <= valid_q[ra2];
			end
		end
	end

	assign rd1 = v1_q ? q1_q : 32'd0;
	assign rd2 = v2_q ? q2_q : 32'd0;
endmodule
`default_nettype wire

[rtl/rv32_dmem.sv]
`default_nettype none
module rv32_dmem #(
	parameter int MEM_WORDS = 32,
	parameter int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] ra,
	input  wire logic          we,
	input  wire logic [AW-1:0] wa,
	input  wire logic [31:0]   wd,
	output logic [31:0]        rd,
	output logic               busy
);
	localparam logic [AW-1:0] LAST = AW'(MEM_WORDS - 1);

	logic [31:0]   mem [MEM_WORDS];
	logic [31:0]   q_q;
	logic [AW-1:0] clr_q;
	logic          busy_q;

	// After reset every word is swept to zero, one word per cycle.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= 32'd0;
		end else if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			q_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q <= '0;
		end else if (busy_q) begin
			if (clr_q == LAST) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign rd = q_q;
	assign busy = busy_q;
endmodule
`default_nettype wire

[rtl/rv32_checker.sv]
`default_nettype none
module rv32_checker
	import rv32_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] status,
	input wire logic       reg_write,
	input wire logic       mem_write,
	input wire logic [4:0] dest_reg
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> !reg_write && !mem_write) else $error("write on fault");
	a_x0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_write |-> dest_reg != 5'd0) else $error("x0 written");
endmodule
bind rv32i_subset_execute rv32_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.status(status), .reg_write(reg_write), .mem_write(mem_write), .dest_reg(dest_reg)
);
`default_nettype wire
